### hdl/ttps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types and codes of the transposition table probe store.
// ----------------------------------------------------------------------------
package ttps_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] kind_t;

	localparam func_t FUNC_PROBE = 2'd0;
	localparam func_t FUNC_STORE = 2'd1;
	localparam func_t FUNC_CLEAR = 2'd2;

	localparam kind_t KIND_EXACT = 2'd0;
	localparam kind_t KIND_UPPER = 2'd1;
	localparam kind_t KIND_LOWER = 2'd2;

	localparam int KEY_W   = 64;
	localparam int DEPTH_W = 8;
	localparam int SCORE_W = 16;

	typedef struct packed {
		kind_t                kind;
		logic [DEPTH_W-1:0]   depth;
		logic [SCORE_W-1:0]   score;
	} entry_payload_t;

	localparam int PAYLOAD_W = $bits(entry_payload_t);

	typedef struct packed {
		logic [DEPTH_W-1:0]   depth;
		logic [SCORE_W-1:0]   alpha;
		logic [SCORE_W-1:0]   beta;
	} probe_window_t;

endpackage
`default_nettype wire

### hdl/ttps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ttps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

### hdl/ttps_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_sweep
// Clearing sequencer that walks every table entry once after reset and
// after each clear item.
// ----------------------------------------------------------------------------
module ttps_sweep #(
	parameter int INDEX_BITS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	output logic [INDEX_BITS-1:0]      addr
);

	logic                  busy_q;
	logic [INDEX_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule
`default_nettype wire

### hdl/ttps_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_eval
// Hit decision of a probe from the entry read out of the table.
// ----------------------------------------------------------------------------
module ttps_eval #(
	parameter int TAG_W = 50
) (
	input  wire logic                     entry_valid,
	input  wire logic [TAG_W-1:0]         entry_tag,
	input  wire ttps_pkg::entry_payload_t entry,
	input  wire logic [TAG_W-1:0]         probe_tag,
	input  wire ttps_pkg::probe_window_t  window,
	output logic                          hit,
	output logic [ttps_pkg::SCORE_W-1:0]  score
);

	import ttps_pkg::*;

	logic match;

	assign match = entry_valid && (entry_tag == probe_tag) && (window.depth < entry.depth);

	always_comb begin
		hit   = 1'b0;
		score = '0;
		if (match) begin
			case (entry.kind)
				KIND_EXACT: begin
					hit   = 1'b1;
					score = entry.score;
				end
				KIND_UPPER: begin
					if ($signed(entry.score) <= $signed(window.alpha)) begin
						hit   = 1'b1;
						score = window.alpha;
					end
				end
				KIND_LOWER: begin
					if ($signed(entry.score) >= $signed(window.beta)) begin
						hit   = 1'b1;
						score = window.beta;
					end
				end
				default: begin
					hit   = 1'b0;
					score = '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/transposition_table_probe_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transposition_table_probe_store
// Direct-mapped transposition table holding search results per position key.
// ----------------------------------------------------------------------------
// Probes and stores are accepted one per cycle while no sweep runs and the
// response register is not stalled by rsp_ready; the table RAM read and stage
// s1 are registered first, then the result in the response register.
// The table lives in one single-port RAM of 2^INDEX_BITS words, each holding
// a valid bit, the key bits above the index, score, depth and kind. A clear
// item, and reset, start a sweep that writes every word invalid, one per
// cycle: no item is accepted while it runs after reset or a clear item.
module transposition_table_probe_store #(
	parameter int INDEX_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ttps_pkg::func_t               func,
	input  wire logic [ttps_pkg::KEY_W-1:0]    key,
	input  wire logic [ttps_pkg::DEPTH_W-1:0]  search_depth,
	input  wire logic signed [ttps_pkg::SCORE_W-1:0] alpha,
	input  wire logic signed [ttps_pkg::SCORE_W-1:0] beta,
	input  wire logic signed [ttps_pkg::SCORE_W-1:0] new_score,
	input  wire ttps_pkg::kind_t               new_kind,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic                               hit,
	output logic signed [ttps_pkg::SCORE_W-1:0] result_score
);

	import ttps_pkg::*;

	localparam int TAG_W  = KEY_W - INDEX_BITS;
	localparam int WORD_W = 1 + TAG_W + PAYLOAD_W;
	localparam int DEPTH  = 1 << INDEX_BITS;

	logic                  accept;
	logic                  advance;
	logic                  sweep_busy;
	logic [INDEX_BITS-1:0] sweep_addr;

	logic                  ram_we;
	logic                  ram_re;
	logic [INDEX_BITS-1:0] ram_addr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_W-1:0]     ram_rdata;

	entry_payload_t        wr_entry;
	entry_payload_t        rd_entry;
	logic                  rd_valid;
	logic [TAG_W-1:0]      rd_tag;

	logic                  valid_s1;
	logic                  probe_s1;
	logic [TAG_W-1:0]      tag_s1;
	probe_window_t         window_s1;

	logic                  eval_hit;
	logic [SCORE_W-1:0]    eval_score;

	logic                  rsp_valid_q;
	logic                  hit_q;
	logic [SCORE_W-1:0]    score_q;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !sweep_busy && (!valid_s1 || advance);
	assign accept    = req_valid && req_ready;

	assign wr_entry.kind  = new_kind;
	assign wr_entry.depth = search_depth;
	assign wr_entry.score = new_score;

	assign ram_re    = accept && (func == FUNC_PROBE);
	assign ram_we    = sweep_busy || (accept && (func == FUNC_STORE));
	assign ram_addr  = sweep_busy ? sweep_addr : key[INDEX_BITS-1:0];
	assign ram_wdata = sweep_busy ? '0 : {1'b1, key[KEY_W-1:INDEX_BITS], wr_entry};

	ttps_sweep #(
		.INDEX_BITS(INDEX_BITS)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && (func == FUNC_CLEAR)),
		.busy  (sweep_busy),
		.addr  (sweep_addr)
	);

	ttps_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_valid = ram_rdata[WORD_W-1];
	assign rd_tag   = ram_rdata[WORD_W-2:PAYLOAD_W];
	assign rd_entry = ram_rdata[PAYLOAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			probe_s1        <= (func == FUNC_PROBE);
			tag_s1          <= key[KEY_W-1:INDEX_BITS];
			window_s1.depth <= search_depth;
			window_s1.alpha <= alpha;
			window_s1.beta  <= beta;
		end
	end

	ttps_eval #(
		.TAG_W(TAG_W)
	) u_eval (
		.entry_valid(rd_valid),
		.entry_tag  (rd_tag),
		.entry      (rd_entry),
		.probe_tag  (tag_s1),
		.window     (window_s1),
		.hit        (eval_hit),
		.score      (eval_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			hit_q   <= probe_s1 && eval_hit;
			score_q <= probe_s1 ? eval_score : '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign result_score = score_q;

endmodule
`default_nettype wire
